FILE: sv/msba_pkg.sv
// Shared types and constants of the multi-span bump allocator.
// Used by the channel interfaces, the top level and its checker.
package msba_pkg;

  localparam int MAX_SPANS = 16;
  localparam int ADDR_BITS = 32;

  localparam int IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_GROW    = 3'd1,
    CMD_SHRINK  = 3'd2,
    CMD_RESTORE = 3'd3,
    CMD_CLEAN   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] req_size;
    logic [3:0]  align_log2;
    logic [31:0] span_base_in;
    logic [3:0]  mark_index;
    logic [31:0] mark_offset;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [31:0] released_size;
    logic [3:0]  cur_index;
    logic [31:0] cur_offset;
  } out_word_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
  } span_ent_t;

endpackage

FILE: sv/msba_if.sv
// Valid/ready channel interfaces for the allocator's request and result words.
// Depends on msba_pkg for the word types.
interface msba_in_if import msba_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msba_out_if import msba_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/multi_span_bump_allocator.sv
// Top level of the multi-span bump allocator: sequencer, span table and fit unit.
// Depends on msba_pkg and the channel interfaces in msba_if.sv.
//
// The allocator keeps a table of up to MAX_SPANS memory spans (base, size) and
// a cursor (span index, offset). Each request word carries a command: alloc,
// grow, shrink, restore or clean, and yields exactly one result word with a
// success flag, an address, a released size and the cursor after the command.
// Requests are handled one at a time; the request channel is ready only while
// the sequencer is idle, and a finished result waits in an output register, so
// the next request is taken even while the previous result is still stalled.
// Grow, clean and restore to the current span are settled in the execute
// state; shrink and restore to an earlier span also pass through a state that
// takes the table read, since the span table is a memory with a registered
// read port. Alloc checks the current span, then scans k later spans (k up to
// MAX_SPANS - 1) when it does not fit, swaps a found span into the slot after
// the current one in the swap write states when needed, and so on. The scan
// rate is set by the single table read port and the one shared fit unit, which
// checks one span per cycle. No clearing pass is needed after reset; only table
// entries below the span count are ever read.

module multi_span_bump_allocator import msba_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  msba_in_if.sink      in_i,
  msba_out_if.source   out_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_EXEC   = 10'b0000000010,
    ST_A_CUR  = 10'b0000000100,
    ST_A_SCAN = 10'b0000001000,
    ST_SW1    = 10'b0000010000,
    ST_SW2    = 10'b0000100000,
    ST_A_FIN  = 10'b0001000000,
    ST_SHR    = 10'b0010000000,
    ST_RST    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic        fit;
    logic [31:0] at;
    logic [31:0] sum;
  } fit_t;

  // The fit unit: pads the cursor address up to the alignment and checks
  // that offset + pad + size stays within the span. An offset already past
  // the span end can never fit, which matches an empty remainder.
  function automatic fit_t fit_calc(input logic [31:0] sz, input logic [31:0] off,
                                    input logic [31:0] base, input logic [3:0] lg,
                                    input logic [31:0] req);
    logic [14:0] low;
    logic [15:0] msk;
    logic [14:0] pad;
    logic [33:0] s;
    fit_t        r;
    low   = base[14:0] + off[14:0];
    msk   = (16'd1 << lg) - 16'd1;
    pad   = (15'd0 - low) & msk[14:0];
    s     = 34'(off) + 34'(pad) + 34'(req);
    r.fit = (s <= 34'(sz));
    r.at  = off + 32'(pad);
    r.sum = s[31:0];
    return r;
  endfunction

  state_e            state_q, state_d;
  in_word_t          req_q;
  logic [CNT_W-1:0]  span_cnt_q, span_cnt_d;
  logic [IDX_W-1:0]  cur_span_q, cur_span_d;
  logic [31:0]       cur_off_q, cur_off_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [IDX_W-1:0]  new_span_q, new_span_d;
  span_ent_t         hit_q, hit_d;
  span_ent_t         nxe_q, nxe_d;
  logic [31:0]       at_q, at_d;
  logic [31:0]       new_off_q, new_off_d;
  logic              res_ok_q, res_ok_d;
  logic [31:0]       res_addr_q, res_addr_d;
  logic [31:0]       res_rel_q, res_rel_d;
  out_word_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Span table memory.
  span_ent_t         span_mem_q [MAX_SPANS];
  span_ent_t         span_rd_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  span_ent_t         mem_wd;

  fit_t              fit_res;
  logic [31:0]       fit_off;
  logic [CNT_W-1:0]  last_cnt;
  logic [IDX_W-1:0]  nx_idx;
  logic [CNT_W-1:0]  nx_cnt;
  logic [CNT_W-1:0]  scan_nx_cnt;
  logic [CMP_W-1:0]  midx_w, cs_w, cnt_w;
  logic [ADDR_BITS-1:0] addr_sum;
  logic              in_acc;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign last_cnt    = span_cnt_q - CNT_W'(1);
  assign nx_idx      = cur_span_q + IDX_W'(1);
  assign nx_cnt      = CNT_W'(cur_span_q) + CNT_W'(1);
  assign scan_nx_cnt = CNT_W'(scan_q) + CNT_W'(1);
  assign midx_w      = CMP_W'(req_q.mark_index);
  assign cs_w        = CMP_W'(cur_span_q);
  assign cnt_w       = CMP_W'(span_cnt_q);
  assign addr_sum    = ADDR_BITS'(hit_q.base) + ADDR_BITS'(at_q);

  // While scanning later spans the pad is taken from the span base alone.
  assign fit_off = (state_q == ST_A_CUR) ? cur_off_q : 32'd0;
  assign fit_res = fit_calc(span_rd_q.size, fit_off, span_rd_q.base,
                            req_q.align_log2, req_q.req_size);

  always_comb begin
    state_d     = state_q;
    span_cnt_d  = span_cnt_q;
    cur_span_d  = cur_span_q;
    cur_off_d   = cur_off_q;
    scan_d      = scan_q;
    new_span_d  = new_span_q;
    hit_d       = hit_q;
    nxe_d       = nxe_q;
    at_d        = at_q;
    new_off_d   = new_off_q;
    res_ok_d    = res_ok_q;
    res_addr_d  = res_addr_q;
    res_rel_d   = res_rel_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ok_d   = 1'b0;
        res_addr_d = 32'd0;
        res_rel_d  = 32'd0;
        state_d    = ST_DONE;
        case (req_q.cmd)
          CMD_ALLOC: begin
            if (req_q.req_size != 32'd0 && span_cnt_q != '0 &&
                CNT_W'(cur_span_q) < span_cnt_q) begin
              mem_re  = 1'b1;
              mem_ra  = cur_span_q;
              state_d = ST_A_CUR;
            end
          end
          CMD_GROW: begin
            if (req_q.req_size != 32'd0 && span_cnt_q < CNT_W'(MAX_SPANS)) begin
              if (span_cnt_q == '0) begin
                cur_span_d = '0;
                cur_off_d  = 32'd0;
              end
              mem_we      = 1'b1;
              mem_wa      = IDX_W'(span_cnt_q);
              mem_wd.base = req_q.span_base_in;
              mem_wd.size = req_q.req_size;
              span_cnt_d  = span_cnt_q + CNT_W'(1);
              res_ok_d    = 1'b1;
            end
          end
          CMD_SHRINK: begin
            // The last span may go unless the cursor is in it, except when
            // the cursor sits at the very start of the arena.
            if (span_cnt_q != '0 &&
                !(CNT_W'(cur_span_q) == last_cnt &&
                  !(cur_span_q == '0 && cur_off_q == 32'd0))) begin
              mem_re  = 1'b1;
              mem_ra  = IDX_W'(last_cnt);
              state_d = ST_SHR;
            end
          end
          CMD_RESTORE: begin
            if (midx_w <= cs_w) begin
              if (midx_w == cs_w) begin
                if (req_q.mark_offset <= cur_off_q) begin
                  cur_span_d = IDX_W'(req_q.mark_index);
                  cur_off_d  = req_q.mark_offset;
                  res_ok_d   = 1'b1;
                end
              end else if (midx_w < cnt_w) begin
                mem_re  = 1'b1;
                mem_ra  = IDX_W'(req_q.mark_index);
                state_d = ST_RST;
              end else if (req_q.mark_offset == 32'd0) begin
                cur_span_d = IDX_W'(req_q.mark_index);
                cur_off_d  = 32'd0;
                res_ok_d   = 1'b1;
              end
            end
          end
          CMD_CLEAN: begin
            cur_span_d = '0;
            cur_off_d  = 32'd0;
            res_ok_d   = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_A_CUR: begin
        if (fit_res.fit) begin
          at_d       = fit_res.at;
          new_off_d  = fit_res.sum;
          hit_d      = span_rd_q;
          new_span_d = cur_span_q;
          state_d    = ST_A_FIN;
        end else if (nx_cnt < span_cnt_q) begin
          mem_re  = 1'b1;
          mem_ra  = nx_idx;
          scan_d  = nx_idx;
          state_d = ST_A_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_A_SCAN: begin
        // The read of the next span is issued while this one is checked.
        if (scan_q == nx_idx) begin
          nxe_d = span_rd_q;
        end
        if (fit_res.fit) begin
          at_d       = fit_res.at;
          new_off_d  = fit_res.sum;
          hit_d      = span_rd_q;
          new_span_d = nx_idx;
          state_d    = (scan_q != nx_idx) ? ST_SW1 : ST_A_FIN;
        end else if (scan_nx_cnt < span_cnt_q) begin
          mem_re = 1'b1;
          mem_ra = scan_q + IDX_W'(1);
          scan_d = scan_q + IDX_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SW1: begin
        mem_we  = 1'b1;
        mem_wa  = nx_idx;
        mem_wd  = hit_q;
        state_d = ST_SW2;
      end
      ST_SW2: begin
        mem_we  = 1'b1;
        mem_wa  = scan_q;
        mem_wd  = nxe_q;
        state_d = ST_A_FIN;
      end
      ST_A_FIN: begin
        res_ok_d   = 1'b1;
        res_addr_d = 32'(addr_sum);
        cur_span_d = new_span_q;
        cur_off_d  = new_off_q;
        state_d    = ST_DONE;
      end
      ST_SHR: begin
        res_ok_d   = 1'b1;
        res_addr_d = 32'(ADDR_BITS'(span_rd_q.base));
        res_rel_d  = span_rd_q.size;
        span_cnt_d = last_cnt;
        state_d    = ST_DONE;
      end
      ST_RST: begin
        if (req_q.mark_offset <= span_rd_q.size) begin
          cur_span_d = IDX_W'(req_q.mark_index);
          cur_off_d  = req_q.mark_offset;
          res_ok_d   = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_d.ok            = res_ok_q;
          out_d.address       = res_addr_q;
          out_d.released_size = res_rel_q;
          out_d.cur_index     = 4'(cur_span_q);
          out_d.cur_offset    = cur_off_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      span_cnt_q  <= '0;
      cur_span_q  <= '0;
      cur_off_q   <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      span_cnt_q  <= span_cnt_d;
      cur_span_q  <= cur_span_d;
      cur_off_q   <= cur_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_i.data;
    end
    scan_q     <= scan_d;
    new_span_q <= new_span_d;
    hit_q      <= hit_d;
    nxe_q      <= nxe_d;
    at_q       <= at_d;
    new_off_q  <= new_off_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    res_rel_q  <= res_rel_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      span_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      span_rd_q <= span_mem_q[mem_ra];
    end
  end

endmodule

FILE: sv/msba_checker.sv
// Port-level assertions for the multi-span bump allocator and their bind.
// Depends on the top level multi_span_bump_allocator and its channel interfaces.
module msba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_ok_i,
  input logic [31:0] out_addr_i,
  input logic [31:0] out_rel_i
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i) && $stable(out_rel_i))
    else $error("result word changed while stalled");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while a request is in progress");

  // A new result only comes out of a request in progress.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a request in progress");

  // A failed command reports neither an address nor a released span.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ok_i |-> out_addr_i == 32'd0 && out_rel_i == 32'd0)
    else $error("failed command reported an address or size");

endmodule

bind multi_span_bump_allocator msba_checker u_msba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ok_i    (out_o.data.ok),
  .out_addr_i  (out_o.data.address),
  .out_rel_i   (out_o.data.released_size)
);

FILE: test/alloc_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the multi-span bump allocator: keeps its own span table and cursor,
// predicts one result word per accepted request word and compares it with the block.
// Depends on msba_pkg for the word types and the command codes.
module alloc_result_checker import msba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        words_pending_o
);

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

  logic [31:0] base_tab [MAX_SPANS];
  logic [31:0] size_tab [MAX_SPANS];
  int          live_spans = 0;
  int          cursor_span = 0;
  logic [31:0] cursor_off = '0;

  out_word_t   expected_results [$];
  out_word_t   want;
  int          fail_count = 0;
  int          pending_cnt = 0;

  assign fail_count_o    = fail_count;
  assign words_pending_o = pending_cnt;

  // Bytes needed to lift an address to the next multiple of 2**lg.
  function automatic logic [63:0] align_pad(logic [63:0] addr, logic [3:0] lg);
    return (64'd0 - (addr & ADDR_MASK)) & ((64'd1 << lg) - 64'd1);
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t   r;
    logic        ok;
    logic [63:0] addr, rel, left, pad, at, sz, req;
    logic [31:0] lim, tmp_base, tmp_size;
    int          i, nx, last;
    ok   = 1'b0;
    addr = '0;
    rel  = '0;
    req  = {32'd0, w.req_size};
    case (w.cmd)
      CMD_ALLOC: begin
        if (w.req_size != 0 && live_spans != 0 && cursor_span < live_spans) begin
          left = (cursor_off > size_tab[cursor_span]) ? 64'd0 :
                 {32'd0, size_tab[cursor_span]} - {32'd0, cursor_off};
          pad = align_pad({32'd0, base_tab[cursor_span]} + {32'd0, cursor_off},
                          w.align_log2);
          if (pad <= left && req <= left - pad) begin
            at         = {32'd0, cursor_off} + pad;
            cursor_off = 32'(at + req);
            addr       = ({32'd0, base_tab[cursor_span]} + at) & ADDR_MASK;
            ok         = 1'b1;
          end
          // First later span that fits is swapped into the slot after the cursor.
          nx = cursor_span + 1;
          for (i = nx; i < live_spans && !ok; i++) begin
            sz  = {32'd0, size_tab[i]};
            pad = align_pad({32'd0, base_tab[i]}, w.align_log2);
            if (pad <= sz && req <= sz - pad) begin
              if (i != nx) begin
                tmp_base     = base_tab[nx];
                tmp_size     = size_tab[nx];
                base_tab[nx] = base_tab[i];
                size_tab[nx] = size_tab[i];
                base_tab[i]  = tmp_base;
                size_tab[i]  = tmp_size;
              end
              cursor_span = nx;
              cursor_off  = 32'(pad + req);
              addr        = ({32'd0, base_tab[nx]} + pad) & ADDR_MASK;
              ok          = 1'b1;
            end
          end
        end
      end
      CMD_GROW: begin
        if (w.req_size != 0 && live_spans < MAX_SPANS) begin
          if (live_spans == 0) begin
            cursor_span = 0;
            cursor_off  = '0;
          end
          base_tab[live_spans] = w.span_base_in;
          size_tab[live_spans] = w.req_size;
          live_spans++;
          ok = 1'b1;
        end
      end
      CMD_SHRINK: begin
        if (live_spans != 0) begin
          last = live_spans - 1;
          if (!(cursor_span == last && !(cursor_span == 0 && cursor_off == 0))) begin
            addr           = {32'd0, base_tab[last]} & ADDR_MASK;
            rel            = {32'd0, size_tab[last]};
            base_tab[last] = '0;
            size_tab[last] = '0;
            live_spans     = last;
            ok             = 1'b1;
          end
        end
      end
      CMD_RESTORE: begin
        if (int'(w.mark_index) <= cursor_span) begin
          if (int'(w.mark_index) == cursor_span) begin
            lim = cursor_off;
          end else begin
            lim = (int'(w.mark_index) < live_spans) ? size_tab[w.mark_index] : 32'd0;
          end
          if (w.mark_offset <= lim) begin
            cursor_span = int'(w.mark_index);
            cursor_off  = w.mark_offset;
            ok          = 1'b1;
          end
        end
      end
      CMD_CLEAN: begin
        cursor_span = 0;
        cursor_off  = '0;
        ok          = 1'b1;
      end
      default: begin
      end
    endcase
    r.ok            = ok;
    r.address       = addr[31:0];
    r.released_size = rel[31:0];
    r.cur_index     = 4'(cursor_span);
    r.cur_offset    = cursor_off;
    return r;
  endfunction

  task automatic note_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
               $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_spans  = 0;
      cursor_span = 0;
      cursor_off  = '0;
      expected_results.delete();
      pending_cnt = 0;
    end else begin
      // The result leaving now always belongs to an earlier request word.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with nothing expected, expected none, actual %h",
                   $time, out_word_i);
        end else begin
          want = expected_results.pop_front();
          note_field("ok", 32'(want.ok), 32'(out_word_i.ok));
          note_field("address", want.address, out_word_i.address);
          note_field("released_size", want.released_size, out_word_i.released_size);
          note_field("cur_index", 32'(want.cur_index), 32'(out_word_i.cur_index));
          note_field("cur_offset", want.cur_offset, out_word_i.cur_offset);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_result(in_word_i));
      end
      pending_cnt = expected_results.size();
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the multi-span bump allocator: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on msba_pkg, msba_if.sv,
// the allocator RTL and alloc_result_checker.
module tb_top;
  import msba_pkg::*;

  // Roughly 25 directed words followed by about 400 random ones.
  localparam int TOTAL_ITEMS      = 425;
  // The last words go through with no idling on either side.
  localparam int TAIL_ITEMS       = 40;
  // After this many words the result side holds off for a long stretch so that
  // the output register fills, the sequencer stops and the request side stalls.
  localparam int HOLD_AFTER_WORDS = 60;
  localparam int LONG_HOLD        = 400;
  // Extra wait at the end, well beyond the longest alloc.
  localparam int DRAIN_CYCLES     = 4 * (MAX_SPANS + 6);
  // Cycles with no word moving on either channel before the run is called hung.
  // The long hold-off is the longest legal quiet stretch, so this is ten times it.
  localparam int WATCHDOG_LIMIT   = 10 * LONG_HOLD;

  // Command codes the block does not define; they must leave the state alone.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic clk_i;
  logic rst_ni = 1'b0;

  msba_in_if  in_if ();
  msba_out_if out_if ();

  int fail_count;
  int words_pending;
  int words_sent  = 0;
  bit tail_phase  = 1'b0;
  bit gap_mode    = 1'b1;

  multi_span_bump_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  alloc_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_i      (in_if.ready),
    .in_word_i       (in_if.data),
    .out_valid_i     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_word_i      (out_if.data),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offers one request word from the falling edge on and holds it until the block
  // takes it at a rising edge. Afterwards the request side may go idle for a burst.
  // Valid is left high for the next word, so it is never dropped and raised again
  // within one time step.
  task automatic send_request(input logic [2:0] cmd, input logic [31:0] req,
                              input logic [3:0] lg, input logic [31:0] base,
                              input logic [3:0] midx, input logic [31:0] moff);
    in_word_t w;
    w.cmd          = cmd;
    w.req_size     = req;
    w.align_log2   = lg;
    w.span_base_in = base;
    w.mark_index   = midx;
    w.mark_offset  = moff;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
    tail_phase = (words_sent >= TOTAL_ITEMS - TAIL_ITEMS);
    // Redraw now and then whether the request side idles at all, which leaves
    // long stretches of back-to-back words between the bursty ones.
    if (words_sent % 25 == 0) gap_mode = ($urandom_range(0, 2) != 0);
    @(negedge clk_i);
    if (!tail_phase && gap_mode && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
  endtask

  // Main stimulus: reset, a directed walk through the corner cases, then random
  // sessions of tear-down, growth and mixed work, then the drain and the verdict.
  initial begin
    int live;
    int n_grow;
    int n_work;
    int pick;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty arena: alloc and shrink fail, restore to the origin succeeds, restore
    // beyond the cursor fails, and a grow of zero bytes fails.
    send_request(CMD_ALLOC, 32'd16, 4'd0, $urandom, 4'd0, $urandom);
    send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(CMD_RESTORE, $urandom, 4'($urandom), $urandom, 4'd0, 32'd0);
    send_request(CMD_RESTORE, $urandom, 4'($urandom), $urandom, 4'd15, 32'd0);
    send_request(CMD_GROW, 32'd0, 4'($urandom), 32'h0000_4000, 4'($urandom), $urandom);
    // Setup with a span just below the top of the address space, so that aligned
    // addresses wrap around to zero. Zero-byte alloc fails.
    send_request(CMD_GROW, 32'h0000_0100, 4'd0, 32'hFFFF_FFF0, 4'd0, 32'd0);
    send_request(CMD_ALLOC, 32'd0, 4'd0, $urandom, 4'($urandom), $urandom);
    send_request(CMD_ALLOC, 32'd1, 4'd0, $urandom, 4'($urandom), $urandom);
    // Alignment beyond twelve is still honored as a power of two.
    send_request(CMD_ALLOC, 32'd4, 4'd15, $urandom, 4'($urandom), $urandom);
    // A tiny span and a maximal one. The next alloc fits only in the last span,
    // which gets swapped into the slot after the current one.
    send_request(CMD_GROW, 32'd16, 4'd0, 32'h0000_2000, 4'd0, 32'd0);
    send_request(CMD_GROW, 32'hFFFF_FFFF, 4'd0, 32'h0000_1000, 4'd0, 32'd0);
    send_request(CMD_ALLOC, 32'h0000_1000, 4'd12, $urandom, 4'($urandom), $urandom);
    // Shrink drops the unused tiny span; the next shrink hits the span in use.
    send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    // Restore to the end of an earlier span succeeds; past the cursor or past the
    // earlier span's size it fails.
    send_request(CMD_RESTORE, $urandom, 4'($urandom), $urandom, 4'd0, 32'h0000_0100);
    send_request(CMD_RESTORE, $urandom, 4'($urandom), $urandom, 4'd1, 32'd0);
    send_request(CMD_RESTORE, $urandom, 4'($urandom), $urandom, 4'd0, 32'h0000_0101);
    // The largest request fills the big span; then nothing fits anywhere.
    send_request(CMD_ALLOC, 32'hFFFF_FFFF, 4'd0, $urandom, 4'($urandom), $urandom);
    send_request(CMD_ALLOC, 32'd1, 4'd3, $urandom, 4'($urandom), $urandom);
    // Undefined commands change nothing and report failure.
    send_request(CMD_UNUSED_HI, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(CMD_UNUSED_LO, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    // Clean, then shrink down to nothing; the last shrink removes the only span
    // while the cursor sits at the origin. Alloc on the emptied arena fails.
    send_request(CMD_CLEAN, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(CMD_ALLOC, 32'd8, 4'd0, $urandom, 4'($urandom), $urandom);

    // Random sessions. Each one tears the arena down (clean, then enough shrinks to
    // empty it), grows a fresh set of spans and runs a mix dominated by allocs of
    // small sizes, so that spans fill, the scan moves on and swaps happen.
    live = 0;
    while (words_sent < TOTAL_ITEMS) begin
      send_request(CMD_CLEAN, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
      repeat (live + 1) begin
        send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
      end
      live = 0;
      // Now and then grow past the table size so that a grow on a full table fails.
      n_grow = ($urandom_range(0, 5) == 0) ? MAX_SPANS + 1 : $urandom_range(1, 6);
      repeat (n_grow) begin
        send_request(CMD_GROW,
                     ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(16, 1024),
                     4'($urandom),
                     ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_F000) : $urandom,
                     4'($urandom), $urandom);
        if (live < MAX_SPANS) live++;
      end
      n_work = $urandom_range(15, 45);
      repeat (n_work) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_request(CMD_ALLOC,
                       ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 256),
                       ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(0, 6)),
                       $urandom, 4'($urandom), $urandom);
        end else if (pick < 75) begin
          send_request(CMD_RESTORE, $urandom, 4'($urandom), $urandom,
                       ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)),
                       ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300));
        end else if (pick < 80) begin
          send_request(CMD_CLEAN, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
        end else if (pick < 86) begin
          send_request(CMD_GROW, $urandom_range(16, 1024), 4'($urandom), $urandom,
                       4'($urandom), $urandom);
          if (live < MAX_SPANS) live++;
        end else if (pick < 91) begin
          send_request(CMD_SHRINK, $urandom, 4'($urandom), $urandom, 4'($urandom), $urandom);
        end else if (pick < 95) begin
          send_request(CMD_ALLOC, 32'd0, 4'($urandom), $urandom, 4'($urandom), $urandom);
        end else begin
          send_request(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom,
                       4'($urandom), $urandom, 4'($urandom), $urandom);
        end
      end
    end

    // All words are in; stop offering and let the outstanding results drain.
    in_if.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side back-pressure. Ready is decided once per falling edge: a running
  // stall counts down first, then the single long hold-off, then random stall
  // bursts while the stall mode is on. The mode is redrawn from time to time,
  // and in the tail of the run ready stays high.
  initial begin
    int stall_left;
    bit long_hold_done;
    bit stall_mode;
    stall_left     = 0;
    long_hold_done = 1'b0;
    stall_mode     = 1'b1;
    out_if.ready   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && words_sent >= HOLD_AFTER_WORDS) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        out_if.ready   <= 1'b0;
      end else if (!tail_phase && stall_mode && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(0, 16);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 39) == 0) stall_mode = ($urandom_range(0, 2) != 0);
    end
  end

  // Watchdog: a hung handshake on either side shows up as a long run of cycles
  // in which no word moves at all.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/msba_pkg.sv
sv/msba_if.sv
sv/multi_span_bump_allocator.sv
sv/msba_checker.sv
test/alloc_result_checker.sv
test/tb_top.sv
